@@ hw/rtl/free_page_stack_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the free page stack allocator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FREE_PAGE_STACK_ALLOCATOR_MACROS_SVH
`define FREE_PAGE_STACK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FPSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/fpsa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsa_pkg
// Types, codes and widths shared by the free page stack allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsa_pkg;

    localparam int CTR_W       = 48;                   // byte counters, addresses
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int FRAME_W     = CTR_W - PAGE_SHIFT;   // frame number width
    localparam int PAGES_W     = FRAME_W + 1;          // page count of a region
    localparam int STACK_DEPTH = 4096;

    localparam logic [CTR_W-1:0] PAGE_BYTES_C = CTR_W'(PAGE_BYTES);

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_LOADER = 2'd1;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_ALLOC = 2'd2,
        FUNC_FREE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_KIND,
        ST_WALK,
        ST_PUSH,
        ST_PFREE,
        ST_PUSED,
        ST_POP,
        ST_AFREE,
        ST_AUSED,
        ST_RESP
    } state_t;

    // request to the shared saturating add/subtract unit
    typedef struct packed {
        logic [CTR_W-1:0] a;
        logic [CTR_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/free_page_stack_allocator.sv @@
// ----------------------------------------------------------------------------
// free_page_stack_allocator
// Page-frame allocator: LIFO stack of free 4 KiB frame numbers in a RAM,
// plus saturating total/used/reserved/free byte counters.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  req     | req_valid, req_stall | func, region_base, region_size,
//          |                      | region_kind, page_number
//  rsp     | rsp_valid, rsp_stall | alloc_frame, status, total_bytes,
//          |                      | used_bytes, reserved_bytes, free_bytes
//
//  Allocate pops and free page pushes; on success each updates free and used.
//  A region adds to total, then used or reserved; a free one walks its pages.
//  Each counter update is one pass through the shared add/subtract unit.
//  req_stall is low only when idle; a stalled result beat holds its registers.
//  Reset clears control state and counters; the stack RAM is not swept, since
//  entries at or above the stack count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module free_page_stack_allocator #(
    parameter int STACK_DEPTH = fpsa_pkg::STACK_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [1:0]                    func,
    input  wire logic [fpsa_pkg::CTR_W-1:0]    region_base,
    input  wire logic [fpsa_pkg::CTR_W-1:0]    region_size,
    input  wire logic [1:0]                    region_kind,
    input  wire logic [fpsa_pkg::FRAME_W-1:0]  page_number,
    // response channel
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [fpsa_pkg::FRAME_W-1:0]       alloc_frame,
    output logic [1:0]                         status,
    output logic [fpsa_pkg::CTR_W-1:0]         total_bytes,
    output logic [fpsa_pkg::CTR_W-1:0]         used_bytes,
    output logic [fpsa_pkg::CTR_W-1:0]         reserved_bytes,
    output logic [fpsa_pkg::CTR_W-1:0]         free_bytes
);
    import fpsa_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);   // stack count, holds DEPTH
    localparam int AW = $clog2(STACK_DEPTH);       // stack address

    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // control
    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                walk_reg,  walk_next;     // push belongs to a region walk

    // counters
    logic [CTR_W-1:0]    total_reg, total_next;
    logic [CTR_W-1:0]    used_reg,  used_next;
    logic [CTR_W-1:0]    resv_reg,  resv_next;
    logic [CTR_W-1:0]    free_reg,  free_next;

    // item payload and walk state
    logic [CTR_W-1:0]    size_reg,     size_next;
    logic [1:0]          kind_reg,     kind_next;
    logic [FRAME_W-1:0]  page_reg,     page_next;   // current frame of the walk
    logic                lowz_reg,     lowz_next;   // base is page aligned
    logic [PAGES_W-1:0]  pages_reg,    pages_next;  // pages left in the walk
    logic [FRAME_W-1:0]  frame_reg,    frame_next;
    logic [1:0]          status_reg,   status_next;

    // shared unit
    alu_req_t            alu_req;
    logic [CTR_W-1:0]    alu_res;

    // stack RAM
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [AW-1:0]       ram_rd_addr;
    logic [FRAME_W-1:0]  ram_rd_data;
    logic [CW-1:0]       count_dec;

    logic                full;
    logic                skip_page;

    assign count_dec   = count_reg - CW'(1);
    assign ram_wr_addr = count_reg[AW-1:0];
    assign ram_rd_addr = count_dec[AW-1:0];
    assign full        = (count_reg == DEPTH_C);
    assign skip_page   = lowz_reg && (page_reg == '0);   // page starting at address 0

    fpsa_alu u_alu (
        .req    (alu_req),
        .result (alu_res)
    );

    fpsa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (page_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            walk_reg  <= 1'b0;
            total_reg <= '0;
            used_reg  <= '0;
            resv_reg  <= '0;
            free_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            total_reg <= total_next;
            used_reg  <= used_next;
            resv_reg  <= resv_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        kind_reg   <= kind_next;
        page_reg   <= page_next;
        lowz_reg   <= lowz_next;
        pages_reg  <= pages_next;
        frame_reg  <= frame_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        total_next  = total_reg;
        used_next   = used_reg;
        resv_next   = resv_reg;
        free_next   = free_reg;
        size_next   = size_reg;
        kind_next   = kind_reg;
        page_next   = page_reg;
        lowz_next   = lowz_reg;
        pages_next  = pages_reg;
        frame_next  = frame_reg;
        status_next = status_reg;

        alu_req     = '0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        req_stall   = 1'b1;
        rsp_valid   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    status_next = STATUS_OK;
                    frame_next  = '0;
                    unique case (func_t'(func))
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            used_next  = '0;
                            resv_next  = '0;
                            free_next  = '0;
                            state_next = ST_RESP;
                        end
                        FUNC_ADD:
                        begin
                            size_next  = region_size;
                            kind_next  = region_kind;
                            page_next  = region_base[CTR_W-1:PAGE_SHIFT];
                            lowz_next  = (region_base[PAGE_SHIFT-1:0] == '0);
                            // partial last page counts as a whole page
                            pages_next = {1'b0, region_size[CTR_W-1:PAGE_SHIFT]}
                                       + PAGES_W'(region_size[PAGE_SHIFT-1:0] != '0);
                            state_next = ST_TOTAL;
                        end
                        FUNC_ALLOC:
                        begin
                            state_next = ST_POP;
                        end
                        FUNC_FREE:
                        begin
                            page_next  = page_number;
                            state_next = ST_PUSH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_TOTAL:
            begin
                alu_req    = '{a: total_reg, b: size_reg, sub: 1'b0};
                total_next = alu_res;
                state_next = ST_KIND;
            end

            ST_KIND:
            begin
                if (kind_reg == KIND_FREE || kind_reg == KIND_LOADER)
                begin
                    alu_req   = '{a: used_reg, b: size_reg, sub: 1'b0};
                    used_next = alu_res;
                end
                else
                begin
                    alu_req   = '{a: resv_reg, b: size_reg, sub: 1'b0};
                    resv_next = alu_res;
                end
                state_next = (kind_reg == KIND_FREE) ? ST_WALK : ST_RESP;
            end

            ST_WALK:
            begin
                if (pages_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else if (skip_page)
                begin
                    page_next  = page_reg + FRAME_W'(1);
                    pages_next = pages_reg - PAGES_W'(1);
                end
                else if (full)
                begin
                    // first page that does not fit ends the walk
                    status_next = STATUS_FULL;
                    state_next  = ST_RESP;
                end
                else
                begin
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                    page_next  = page_reg + FRAME_W'(1);
                    pages_next = pages_reg - PAGES_W'(1);
                    walk_next  = 1'b1;
                    state_next = ST_PFREE;
                end
            end

            ST_PUSH:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                    state_next  = ST_RESP;
                end
                else
                begin
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                    walk_next  = 1'b0;
                    state_next = ST_PFREE;
                end
            end

            ST_PFREE:
            begin
                alu_req    = '{a: free_reg, b: PAGE_BYTES_C, sub: 1'b0};
                free_next  = alu_res;
                state_next = ST_PUSED;
            end

            ST_PUSED:
            begin
                alu_req    = '{a: used_reg, b: PAGE_BYTES_C, sub: 1'b1};
                used_next  = alu_res;
                state_next = walk_reg ? ST_WALK : ST_RESP;
            end

            ST_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = STATUS_EMPTY;
                    state_next  = ST_RESP;
                end
                else
                begin
                    ram_rd_en  = 1'b1;
                    count_next = count_dec;
                    state_next = ST_AFREE;
                end
            end

            ST_AFREE:
            begin
                frame_next = ram_rd_data;
                alu_req    = '{a: free_reg, b: PAGE_BYTES_C, sub: 1'b1};
                free_next  = alu_res;
                state_next = ST_AUSED;
            end

            ST_AUSED:
            begin
                alu_req    = '{a: used_reg, b: PAGE_BYTES_C, sub: 1'b0};
                used_next  = alu_res;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign alloc_frame    = frame_reg;
    assign status         = status_reg;
    assign total_bytes    = total_reg;
    assign used_bytes     = used_reg;
    assign reserved_bytes = resv_reg;
    assign free_bytes     = free_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fpsa_ram.sv @@
// ----------------------------------------------------------------------------
// fpsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsa_ram #(
    parameter int WIDTH = fpsa_pkg::FRAME_W,
    parameter int DEPTH = fpsa_pkg::STACK_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fpsa_alu.sv @@
// ----------------------------------------------------------------------------
// fpsa_alu
// Shared 48-bit add/subtract; adds saturate high, subtracts stop at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsa_alu (
    input  wire fpsa_pkg::alu_req_t          req,
    output logic [fpsa_pkg::CTR_W-1:0]       result
);
    import fpsa_pkg::*;

    logic [CTR_W:0] sum;
    logic [CTR_W:0] diff;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    always_comb
    begin
        if (req.sub)
        begin
            result = diff[CTR_W] ? '0 : diff[CTR_W-1:0];   // borrow: floor at 0
        end
        else
        begin
            result = sum[CTR_W] ? '1 : sum[CTR_W-1:0];     // carry: clamp
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fpsa_checker.sv @@
// ----------------------------------------------------------------------------
// fpsa_checker
// Port-level assertions for the free page stack allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_page_stack_allocator_macros.svh"

module fpsa_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_stall,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_stall,
    input  wire logic [fpsa_pkg::FRAME_W-1:0]  alloc_frame,
    input  wire logic [1:0]                    status,
    input  wire logic [fpsa_pkg::CTR_W-1:0]    total_bytes,
    input  wire logic [fpsa_pkg::CTR_W-1:0]    used_bytes,
    input  wire logic [fpsa_pkg::CTR_W-1:0]    reserved_bytes,
    input  wire logic [fpsa_pkg::CTR_W-1:0]    free_bytes
);
    import fpsa_pkg::*;

    localparam int PAYLOAD_W = FRAME_W + 2 + 4 * CTR_W;

    logic [PAYLOAD_W-1:0] rsp_payload;
    logic                 rsp_held;
    logic                 rsp_empty;
    logic                 status_known;

    assign rsp_payload  = {alloc_frame, status, total_bytes, used_bytes,
                           reserved_bytes, free_bytes};
    assign rsp_held     = rsp_valid && rsp_stall;
    assign rsp_empty    = rsp_valid && (status == STATUS_EMPTY);
    assign status_known = (status == STATUS_OK) || (status == STATUS_EMPTY)
                       || (status == STATUS_FULL);

    // a pending result beat blocks new requests
    `FPSA_ASSERT_IMP(a_one_beat, rsp_valid, req_stall, "request taken while result pending")

    // a stalled result beat holds
    `FPSA_ASSERT_NXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_payload), "beat changed")

    // empty stack answers frame zero
    `FPSA_ASSERT_IMP(a_empty_frame, rsp_empty, alloc_frame == '0, "nonzero frame on empty")

    `FPSA_ASSERT_IMP(a_status_code, rsp_valid, status_known, "undefined status code")

    // an offered request waits out the result beat
    `FPSA_ASSERT_IMP(a_req_idle, rsp_valid && req_valid, req_stall, "request during result beat")

endmodule

bind free_page_stack_allocator fpsa_checker u_fpsa_checker (.*);

`default_nettype wire
